// File: hdl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

   // Geometry of the text store
   localparam int MAX_COLS    = 80;
   localparam int MAX_ROWS    = 25;
   localparam int CELLS       = 2048;
   localparam int ADDR_W      = $clog2(CELLS);

   // Field widths of the register file and the cursor
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int ATTR_W      = 8;
   localparam int CHAR_W      = 8;
   localparam int WORD_W      = CHAR_W + ATTR_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
   localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;

   // Register reset values
   localparam logic [COL_W-1:0]  COLS_RESET = COL_W'(80);
   localparam logic [ROW_W-1:0]  ROWS_RESET = ROW_W'(25);
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd31;

   // Action codes of the request
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] cell_word;
      logic [ADDR_W-1:0] cursor_position;
   } rsp_type;

   // Classified operation handed to the back end
   typedef enum logic [2:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic take;
      logic init_busy;
   } back_status_type;

   // Clamp the column count to 1..MAX_COLS
   function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] cols);
      logic [COL_W-1:0] res;
      if (cols == '0) begin
         res = COL_W'(1);
      end else if (cols > COL_W'(MAX_COLS)) begin
         res = COL_W'(MAX_COLS);
      end else begin
         res = cols;
      end
      return res;
   endfunction

   // Clamp the row count to 1..MAX_ROWS
   function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] nrows);
      logic [ROW_W-1:0] res;
      if (nrows == '0) begin
         res = ROW_W'(1);
      end else if (nrows > ROW_W'(MAX_ROWS)) begin
         res = ROW_W'(MAX_ROWS);
      end else begin
         res = nrows;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hdl/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: hdl/tccw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire tccw_pkg::req_type         req_data,
   input  wire tccw_pkg::back_status_type status,
   output tccw_pkg::queue_head_type       head
);
   import tccw_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd;
   logic                push;
   logic                pop;

   // Classify the request
   always_comb begin
      cmd.char_code  = req_data.char_code;
      cmd.cell_index = req_data.cell_index;
      unique case (req_data.action)
         ACT_PUT: begin
            if (req_data.char_code == NEWLINE_CHAR) begin
               cmd.op = OP_NEWLINE;
            end else if (req_data.char_code == BACKSPACE_CHAR) begin
               cmd.op = OP_BACKSPACE;
            end else begin
               cmd.op = OP_PRINT;
            end
         end
         ACT_READ:  cmd.op = OP_READ;
         ACT_CLEAR: cmd.op = OP_CLEAR;
         default:   cmd.op = OP_NOP;
      endcase
   end

   assign busy = (count_ff == QCNT_W'(QUEUE_DEPTH)) || status.init_busy;
   assign push = start && !busy;
   assign pop  = status.take;

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

// File: hdl/tccw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tccw_pkg::queue_head_type          head,
   output tccw_pkg::back_status_type              status,
   input  wire logic [tccw_pkg::COL_W-1:0]        columns,
   input  wire logic [tccw_pkg::ROW_W-1:0]        rows,
   input  wire logic [tccw_pkg::ATTR_W-1:0]       text_attr,
   output logic                                   rsp_valid,
   output tccw_pkg::rsp_type                      rsp_data
);
   import tccw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_EXEC,
      ST_READ,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_BS_LAST,
      ST_BLANK,
      ST_RESP
   } state_type;

   state_type           state_ff, state_in;
   state_type           ret_ff, ret_in;
   logic                init_ff, init_in;
   cmd_type             cur_ff, cur_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   blank_cnt_ff, blank_cnt_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [COL_W-1:0]    x_ff, x_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [COL_W-1:0]         nc;
   logic [ROW_W-1:0]         nr;
   logic [COL_W:0]           col_inc;
   logic [ROW_W:0]           row_inc;
   logic [COL_W:0]           x_inc;
   logic [ROW_W+COL_W-1:0]   row_base;
   logic [ROW_W+COL_W-1:0]   lin_sum;
   logic [ADDR_W-1:0]        cursor_lin;
   logic [WORD_W-1:0]        blank_word;
   logic                     take;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [WORD_W-1:0]        ram_wr_data;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [WORD_W-1:0]        ram_rd_data;

   tccw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign nc      = eff_cols(columns);
   assign nr      = eff_rows(rows);
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign row_inc = {1'b0, row_ff} + 1'b1;
   assign x_inc   = {1'b0, x_ff} + 1'b1;

   // Shared row times columns product for cell address and cursor position
   assign row_base   = (ROW_W + COL_W)'(row_ff) * (ROW_W + COL_W)'(nc);
   assign lin_sum    = row_base + (ROW_W + COL_W)'(col_ff);
   assign cursor_lin = ADDR_W'(lin_sum);

   // Reset pass always blanks with the reset attribute
   assign blank_word = {(init_ff ? ATTR_RESET : text_attr), BLANK_CHAR};

   assign status.take      = take;
   assign status.init_busy = init_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

   // Sequence one command at a time
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      init_in      = init_ff;
      cur_in       = cur_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      blank_cnt_in = blank_cnt_ff;
      base_in      = base_ff;
      x_in         = x_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      take         = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cursor_lin;
      ram_wr_data  = blank_word;
      ram_rd_addr  = cur_ff.cell_index;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               take    = 1'b1;
               cur_in  = head.cmd;
               word_in = '0;
               if (head.cmd.op == OP_PRINT || head.cmd.op == OP_NEWLINE ||
                   head.cmd.op == OP_BACKSPACE) begin
                  state_in = ST_NORM;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         // Pull a cursor left outside the area back in
         ST_NORM: begin
            state_in = ST_EXEC;
            if (col_ff >= nc) begin
               col_in = '0;
               if (row_inc >= {1'b0, nr}) begin
                  row_in   = '0;
                  ret_in   = ST_EXEC;
                  state_in = ST_BLANK;
               end else begin
                  row_in = row_inc[ROW_W-1:0];
               end
            end else if (row_ff >= nr) begin
               row_in   = '0;
               col_in   = '0;
               ret_in   = ST_EXEC;
               state_in = ST_BLANK;
            end
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (cur_ff.op)
               OP_PRINT: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {text_attr, cur_ff.char_code};
                  if (col_inc >= {1'b0, nc}) begin
                     col_in = '0;
                     if (row_inc >= {1'b0, nr}) begin
                        row_in   = '0;
                        ret_in   = ST_RESP;
                        state_in = ST_BLANK;
                     end else begin
                        row_in = row_inc[ROW_W-1:0];
                     end
                  end else begin
                     col_in = col_inc[COL_W-1:0];
                  end
               end
               OP_NEWLINE: begin
                  col_in = '0;
                  if (row_inc >= {1'b0, nr}) begin
                     row_in   = '0;
                     ret_in   = ST_RESP;
                     state_in = ST_BLANK;
                  end else begin
                     row_in = row_inc[ROW_W-1:0];
                  end
               end
               OP_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_in   = col_ff - 1'b1;
                     x_in     = col_ff - 1'b1;
                     base_in  = ADDR_W'(row_base);
                     state_in = ST_SHIFT_RD;
                  end
               end
               OP_READ: begin
                  ram_rd_addr = cur_ff.cell_index;
                  state_in    = ST_READ;
               end
               OP_CLEAR: begin
                  row_in   = '0;
                  col_in   = '0;
                  ret_in   = ST_RESP;
                  state_in = ST_BLANK;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         // Capture the read cell
         ST_READ: begin
            word_in  = ram_rd_data;
            state_in = ST_RESP;
         end

         // Fetch the cell to the right of the gap
         ST_SHIFT_RD: begin
            ram_rd_addr = base_ff + ADDR_W'(x_ff) + 1'b1;
            if (x_inc < {1'b0, nc}) begin
               state_in = ST_SHIFT_WR;
            end else begin
               state_in = ST_BS_LAST;
            end
         end

         // Move it left by one
         ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + ADDR_W'(x_ff);
            ram_wr_data = ram_rd_data;
            x_in        = x_inc[COL_W-1:0];
            state_in    = ST_SHIFT_RD;
         end

         // Blank the last cell of the row
         ST_BS_LAST: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + ADDR_W'(nc) - 1'b1;
            state_in    = ST_RESP;
         end

         // Sweep the whole store with blanks
         ST_BLANK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = blank_cnt_ff;
            if (blank_cnt_ff == ADDR_W'(CELLS - 1)) begin
               blank_cnt_in = '0;
               init_in      = 1'b0;
               state_in     = ret_ff;
            end else begin
               blank_cnt_in = blank_cnt_ff + 1'b1;
            end
         end

         ST_RESP: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.cell_word       = word_ff;
            rsp_data_in.cursor_position = cursor_lin;
            state_in                    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BLANK;
         ret_ff       <= ST_IDLE;
         init_ff      <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         blank_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         init_ff      <= init_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         blank_cnt_ff <= blank_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         x_ff         <= x_in;
         word_ff      <= word_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/text_console_cell_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell text console writer.
// Request channel: drive req_data and raise start; the request is transferred
// at a clock edge where start is high and busy is low. Actions are put
// character (printable, newline, backspace), read cell and clear screen.
// Response channel: every request yields one response, shown on rsp_data for
// a single cycle with rsp_valid high. The receiver cannot stall it.
// Register port: csr_we, csr_index and csr_wdata write columns (0), rows (1)
// and text_attr (2); write them only while the block is idle.
// Structure: a front end classifies requests into a two-entry command queue; a
// back end sequencer works on one command at a time on a single-port-write,
// registered-read store. The queue takes new requests while the back end is
// still busy with an earlier one, until both entries are full. Backspace
// away from column zero moves each later cell of the row left by one, with a
// read and a write per cell, then blanks the last cell of the row. Any clear,
// including a wrap past the last row, sweeps all 2048 cells at one per cycle.
// Reset: synchronous; afterwards all 2048 cells of the store are swept to
// blanks with attribute 31, and busy stays high until the sweep is done.

module text_console_cell_writer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire tccw_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   output tccw_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [tccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tccw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tccw_pkg::*;

   logic [COL_W-1:0]  columns_ff;
   logic [ROW_W-1:0]  rows_ff;
   logic [ATTR_W-1:0] attr_ff;
   queue_head_type    head;
   back_status_type   status;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLS_RESET;
         rows_ff    <= ROWS_RESET;
         attr_ff    <= ATTR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS:   columns_ff <= csr_wdata[COL_W-1:0];
            CSR_ROWS:      rows_ff    <= csr_wdata[ROW_W-1:0];
            CSR_TEXT_ATTR: attr_ff    <= csr_wdata[ATTR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tccw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .status   (status),
      .head     (head)
   );

   tccw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .columns   (columns_ff),
      .rows      (rows_ff),
      .text_attr (attr_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/tccw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // Reset starts the blanking sweep, so no transfer is possible right after
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // No response comes out of reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // One command at a time: response strobes never fall in adjacent cycles
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobes in adjacent cycles");

   // A transfer cannot produce a response in the very next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !$past(start && !busy) && !$past(rsp_valid, 1) && busy == 1'b0
       && !rsp_valid && $past(busy)) |=> !rsp_valid)
      else $error("response right after a transfer out of a busy period");

endmodule

bind text_console_cell_writer tccw_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

// File: tb/sv/tb_text_console_cell_writer.sv
`timescale 1ns / 1ps

module tb_text_console_cell_writer;
   import tccw_pkg::*;

   // Spare action code, expected to do nothing
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 85;
   // Longest quiet stretch the watchdog allows
   localparam int QUIET_LIMIT     = 40000;
   // Room for a full store sweep before touching the registers
   localparam int SWEEP_PAUSE     = CELLS + 64;

   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  known;
      req_type               item;
      rsp_type               want;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the console: cells, cursor and registers
   logic [WORD_W-1:0] shadow_cells [CELLS];
   logic [COL_W-1:0]  shadow_col;
   logic [ROW_W-1:0]  shadow_row;
   logic [COL_W-1:0]  cfg_cols;
   logic [ROW_W-1:0]  cfg_rows;
   logic [ATTR_W-1:0] cfg_attr;

   rsp_type      pending_rsp [$];
   plan_row_type directed_plan [$];
   rsp_type      oldest;
   int           mismatches   = 0;
   int           quiet_cycles = 0;

   text_console_cell_writer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Column and row counts in use, zero counting as one
   function automatic int active_cols();
      int c;
      c = int'(cfg_cols);
      if (c < 1) return 1;
      if (c > MAX_COLS) return MAX_COLS;
      return c;
   endfunction

   function automatic int active_rows();
      int r;
      r = int'(cfg_rows);
      if (r < 1) return 1;
      if (r > MAX_ROWS) return MAX_ROWS;
      return r;
   endfunction

   task automatic shadow_blank();
      for (int i = 0; i < CELLS; i++) begin
         shadow_cells[i] = {cfg_attr, BLANK_CHAR};
      end
   endtask

   // Start the next row, wrapping to the top with a blank screen
   task automatic shadow_newline(input int nr);
      shadow_col = '0;
      shadow_row = shadow_row + 1'b1;
      if (int'(shadow_row) >= nr) begin
         shadow_row = '0;
         shadow_blank();
      end
   endtask

   task automatic shadow_put(input logic [CHAR_W-1:0] ch);
      int nc;
      int nr;
      int base;
      nc = active_cols();
      nr = active_rows();
      // Pull a cursor left outside a shrunken area back inside
      if (int'(shadow_col) >= nc) begin
         shadow_newline(nr);
      end
      if (int'(shadow_row) >= nr) begin
         shadow_row = '0;
         shadow_col = '0;
         shadow_blank();
      end
      if (ch == NEWLINE_CHAR) begin
         shadow_newline(nr);
      end else if (ch == BACKSPACE_CHAR) begin
         // Column zero leaves everything alone; otherwise close up the row
         if (shadow_col != '0) begin
            shadow_col = shadow_col - 1'b1;
            base = int'(shadow_row) * nc;
            for (int x = int'(shadow_col); x + 1 < nc; x++) begin
               shadow_cells[base + x] = shadow_cells[base + x + 1];
            end
            shadow_cells[base + nc - 1] = {cfg_attr, BLANK_CHAR};
         end
      end else begin
         shadow_cells[int'(shadow_row) * nc + int'(shadow_col)] = {cfg_attr, ch};
         shadow_col = shadow_col + 1'b1;
         if (int'(shadow_col) >= nc) begin
            shadow_newline(nr);
         end
      end
   endtask

   // Apply one command to the shadow and form the response it must give
   task automatic predict_response(input req_type item, output rsp_type res);
      res = '0;
      case (item.action)
         ACT_PUT: begin
            shadow_put(item.char_code);
         end
         ACT_READ: begin
            res.cell_word = shadow_cells[item.cell_index];
         end
         ACT_CLEAR: begin
            shadow_blank();
            shadow_col = '0;
            shadow_row = '0;
         end
         default: begin
         end
      endcase
      res.cursor_position =
         ADDR_W'(int'(shadow_row) * active_cols() + int'(shadow_col));
   endtask

   task automatic note_mismatch(input string what, input int want_v, input int got_v);
      if (mismatches < 10) begin
         $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                  $time, what, want_v, got_v);
      end
      mismatches++;
   endtask

   task automatic add_step(input logic known, input logic [1:0] action,
                           input logic [CHAR_W-1:0] ch, input logic [ADDR_W-1:0] idx,
                           input logic [WORD_W-1:0] word, input logic [ADDR_W-1:0] pos);
      plan_row_type r;
      r = '0;
      r.known = known;
      r.item.action = action;
      r.item.char_code = ch;
      r.item.cell_index = idx;
      r.want.cell_word = word;
      r.want.cursor_position = pos;
      directed_plan.push_back(r);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      directed_plan.push_back(r);
   endtask

   // Hold start high until the transfer, then queue the expected response
   task automatic issue(input req_type item, input logic known, input rsp_type want);
      rsp_type predicted;
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_response(item, predicted);
      pending_rsp.push_back(known ? want : predicted);
   endtask

   // Drop start and let the block drain and finish any sweep
   task automatic settle();
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SWEEP_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COLUMNS:   cfg_cols = val[COL_W-1:0];
         CSR_ROWS:      cfg_rows = val[ROW_W-1:0];
         CSR_TEXT_ATTR: cfg_attr = val[ATTR_W-1:0];
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Mostly puts with random content, plus reads, clears and spare codes
   function automatic req_type random_item();
      req_type it;
      int      sel;
      int      area;
      area = active_cols() * active_rows();
      it.action = ACT_PUT;
      it.char_code = CHAR_W'($urandom_range(0, 255));
      it.cell_index = ADDR_W'($urandom_range(0, CELLS - 1));
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         it.action = ACT_CLEAR;
      end else if (sel < 5) begin
         it.action = ACT_SPARE;
      end else if (sel < 25) begin
         it.action = ACT_READ;
         if ($urandom_range(0, 9) < 6) begin
            it.cell_index = ADDR_W'($urandom_range(0, area - 1));
         end
      end else begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            it.char_code = NEWLINE_CHAR;
         end else if (sel == 1) begin
            it.char_code = BACKSPACE_CHAR;
         end
      end
      return it;
   endfunction

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            note_mismatch("response with nothing pending", 0, int'(rsp_data));
         end else begin
            oldest = pending_rsp.pop_front();
            if (rsp_data.cell_word !== oldest.cell_word) begin
               note_mismatch("cell_word", int'(oldest.cell_word), int'(rsp_data.cell_word));
            end
            if (rsp_data.cursor_position !== oldest.cursor_position) begin
               note_mismatch("cursor_position", int'(oldest.cursor_position),
                             int'(rsp_data.cursor_position));
            end
         end
      end
   end

   // Watchdog: end the run after too long without any transfer or response
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      plan_row_type          step_row;
      req_type               item;
      logic [CSR_DATA_W-1:0] cols_val;
      logic [CSR_DATA_W-1:0] rows_val;
      logic [CSR_DATA_W-1:0] attr_val;
      int                    idle_pct;

      cfg_cols = COLS_RESET;
      cfg_rows = ROWS_RESET;
      cfg_attr = ATTR_RESET;
      shadow_col = '0;
      shadow_row = '0;
      shadow_blank();

      // Reset screen, 80 x 25, attribute 0x1F
      add_step(1, ACT_READ,  8'h00, 11'd0,    16'h1F20, 11'd0);
      add_step(1, ACT_READ,  8'h00, 11'h7FF,  16'h1F20, 11'd0);
      add_step(1, ACT_PUT,   8'h41, 11'd0,    16'h0000, 11'd1);
      add_step(1, ACT_PUT,   8'h00, 11'h7FF,  16'h0000, 11'd2);
      add_step(1, ACT_PUT,   8'hFF, 11'd0,    16'h0000, 11'd3);
      add_step(1, ACT_READ,  8'hFF, 11'd0,    16'h1F41, 11'd3);
      add_step(1, ACT_READ,  8'h00, 11'd2,    16'h1FFF, 11'd3);
      // Backspace mid-row pulls the blank tail left
      add_step(1, ACT_PUT,   BACKSPACE_CHAR, 11'd0, 16'h0000, 11'd2);
      add_step(1, ACT_READ,  8'h00, 11'd2,    16'h1F20, 11'd2);
      add_step(1, ACT_PUT,   NEWLINE_CHAR, 11'd0,   16'h0000, 11'd80);
      // Backspace at column zero is ignored
      add_step(1, ACT_PUT,   BACKSPACE_CHAR, 11'd0, 16'h0000, 11'd80);
      add_step(1, ACT_SPARE, 8'hFF, 11'h7FF,  16'h0000, 11'd80);
      add_step(1, ACT_READ,  8'h00, 11'h7FF,  16'h1F20, 11'd80);
      add_step(1, ACT_PUT,   8'h42, 11'd0,    16'h0000, 11'd81);
      add_step(1, ACT_CLEAR, 8'hFF, 11'h7FF,  16'h0000, 11'd0);
      // Tiny 3 x 2 screen: newline on the last row wraps and blanks
      add_write(CSR_COLUMNS, 8'd3);
      add_write(CSR_ROWS, 8'd2);
      add_write(CSR_TEXT_ATTR, 8'hA5);
      add_step(0, ACT_PUT,   8'h78, 11'd0,    16'h0000, 11'd0);
      add_step(0, ACT_PUT,   NEWLINE_CHAR, 11'd0,   16'h0000, 11'd0);
      add_step(0, ACT_PUT,   8'h79, 11'd0,    16'h0000, 11'd0);
      add_step(1, ACT_PUT,   NEWLINE_CHAR, 11'd0,   16'h0000, 11'd0);
      add_step(1, ACT_READ,  8'h00, 11'd3,    16'hA520, 11'd0);
      add_step(0, ACT_PUT,   8'h61, 11'd0,    16'h0000, 11'd0);
      add_step(0, ACT_PUT,   8'h62, 11'd0,    16'h0000, 11'd0);
      // Shrink to zero columns and rows: cursor left outside the area
      add_write(CSR_COLUMNS, 8'd0);
      add_write(CSR_ROWS, 8'd0);
      add_step(0, ACT_READ,  8'h00, 11'd0,    16'h0000, 11'd0);
      add_step(0, ACT_PUT,   8'h63, 11'd0,    16'h0000, 11'd0);
      add_step(0, ACT_READ,  8'h00, 11'd0,    16'h0000, 11'd0);
      // Oversized register values clamp to the full screen
      add_write(CSR_COLUMNS, 8'd127);
      add_write(CSR_ROWS, 8'd31);
      add_write(CSR_TEXT_ATTR, 8'hFF);
      add_step(0, ACT_PUT,   BACKSPACE_CHAR, 11'd0, 16'h0000, 11'd0);
      add_step(0, ACT_PUT,   8'h7E, 11'd0,    16'h0000, 11'd0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_plan[i]) begin
         step_row = directed_plan[i];
         if (step_row.is_write) begin
            settle();
            write_reg(step_row.reg_idx, step_row.reg_val);
         end else begin
            issue(step_row.item, step_row.known, step_row.want);
         end
      end

      // Random phases, each under its own geometry and attribute
      for (int phase = 0; phase < PHASES; phase++) begin
         attr_val = CSR_DATA_W'($urandom_range(0, 255));
         case (phase)
            0: begin
               cols_val = 8'd127;
               rows_val = 8'd31;
               attr_val = 8'h00;
            end
            1: begin
               cols_val = 8'd1;
               rows_val = 8'd1;
               attr_val = 8'hFF;
            end
            2: begin
               cols_val = 8'd0;
               rows_val = 8'd4;
            end
            3: begin
               cols_val = 8'd5;
               rows_val = 8'd0;
            end
            4: begin
               cols_val = 8'd80;
               rows_val = 8'd25;
            end
            default: begin
               cols_val = CSR_DATA_W'($urandom_range(0, 127));
               rows_val = CSR_DATA_W'($urandom_range(0, 31));
            end
         endcase
         settle();
         write_reg(CSR_COLUMNS, cols_val);
         write_reg(CSR_ROWS, rows_val);
         write_reg(CSR_TEXT_ATTR, attr_val);

         // No source gaps in the final phase
         idle_pct = (phase == PHASES - 1) ? 0 : $urandom_range(0, 2) * 25;
         repeat (ITEMS_PER_PHASE) begin
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 10)) @(posedge clock);
            end
            item = random_item();
            issue(item, 1'b0, '0);
         end
      end
      start <= 1'b0;

      // Drain, then watch for stray responses
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
